// ===== hdl/wbalu_pkg.sv =====
// shared types, operation codes and flag layout for the word/byte alu
package wbalu_pkg;

  // item kinds
  localparam logic [2:0] KIND_TWO_OP = 3'd0;
  localparam logic [2:0] KIND_ONE_OP = 3'd1;
  localparam logic [2:0] KIND_FLAGS  = 3'd2;
  localparam logic [2:0] KIND_BRANCH = 3'd3;
  localparam logic [2:0] KIND_COUNT  = 3'd4;

  // two-operand operations
  localparam logic [5:0] OP2_XCHG = 6'o00;
  localparam logic [5:0] OP2_MOV  = 6'o01;
  localparam logic [5:0] OP2_CMP  = 6'o02;
  localparam logic [5:0] OP2_BIT  = 6'o03;
  localparam logic [5:0] OP2_BIC  = 6'o04;
  localparam logic [5:0] OP2_BIS  = 6'o05;
  localparam logic [5:0] OP2_AND  = 6'o06;
  localparam logic [5:0] OP2_XOR  = 6'o07;
  localparam logic [5:0] OP2_ADD  = 6'o10;
  localparam logic [5:0] OP2_SUB  = 6'o11;

  // one-operand operations
  localparam logic [5:0] OP1_SWAB = 6'o00;
  localparam logic [5:0] OP1_CLR  = 6'o20;
  localparam logic [5:0] OP1_COM  = 6'o21;
  localparam logic [5:0] OP1_INC  = 6'o22;
  localparam logic [5:0] OP1_DEC  = 6'o23;
  localparam logic [5:0] OP1_NEG  = 6'o24;
  localparam logic [5:0] OP1_ADC  = 6'o25;
  localparam logic [5:0] OP1_SBC  = 6'o26;
  localparam logic [5:0] OP1_TST  = 6'o27;
  localparam logic [5:0] OP1_ROR  = 6'o30;
  localparam logic [5:0] OP1_ROL  = 6'o31;
  localparam logic [5:0] OP1_ASR  = 6'o32;
  localparam logic [5:0] OP1_ASL  = 6'o33;
  localparam logic [5:0] OP1_RCR  = 6'o34;
  localparam logic [5:0] OP1_RCL  = 6'o35;

  // branch conditions
  localparam logic [5:0] BR_BR   = 6'o60;
  localparam logic [5:0] BR_BNE  = 6'o61;
  localparam logic [5:0] BR_BEQ  = 6'o62;
  localparam logic [5:0] BR_BGE  = 6'o63;
  localparam logic [5:0] BR_BLT  = 6'o64;
  localparam logic [5:0] BR_BGT  = 6'o65;
  localparam logic [5:0] BR_BLE  = 6'o66;
  localparam logic [5:0] BR_BPL  = 6'o67;
  localparam logic [5:0] BR_BMI  = 6'o70;
  localparam logic [5:0] BR_BHI  = 6'o71;
  localparam logic [5:0] BR_BLOS = 6'o72;
  localparam logic [5:0] BR_BVC  = 6'o73;
  localparam logic [5:0] BR_BVS  = 6'o74;
  localparam logic [5:0] BR_BCC  = 6'o75;
  localparam logic [5:0] BR_BCS  = 6'o76;

  // condition codes, same bit order as flag_mask
  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  // one input word
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  op;
    logic        byte_mode;
    logic [15:0] src_value;
    logic [15:0] dst_value;
    logic [3:0]  flag_mask;
  } item_t;

  // one result word
  typedef struct packed {
    logic [15:0] result;
    logic        write_result;
    logic [15:0] src_result;
    logic        write_src;
    flags_t      flags;
    logic        branch_taken;
  } res_t;

endpackage

// ===== hdl/wbalu_exec.sv =====
// single-pass alu: operation decode, arithmetic, flag update and branch test
module wbalu_exec (
  input  wbalu_pkg::item_t  item,
  input  wbalu_pkg::flags_t flags_in,
  output wbalu_pkg::res_t   res
);

  logic                byte_eff;
  logic [16:0]         a;
  logic [16:0]         d;
  logic [16:0]         sign17;
  logic [16:0]         r;
  logic                wr;
  logic                wsrc;
  logic [15:0]         srcres;
  logic [15:0]         res16;
  logic                taken;
  logic                upd_nz;
  logic                shift;
  logic                nc;
  logic                cin;
  wbalu_pkg::flags_t   fl;

  // sign bit at the operation width
  function automatic logic sign_of(input logic [16:0] x, input logic bm);
    return bm ? x[7] : x[15];
  endfunction

  // zero test at the operation width
  function automatic logic zero_of(input logic [16:0] x, input logic bm);
    return bm ? (x[7:0] == 8'h00) : (x[15:0] == 16'h0000);
  endfunction

  // bit just above the operation width
  function automatic logic carry_of(input logic [16:0] x, input logic bm);
    return bm ? x[8] : x[16];
  endfunction

  // byte results are sign-extended to a full word
  function automatic logic [15:0] widen(input logic [16:0] x, input logic bm);
    return bm ? {{8{x[7]}}, x[7:0]} : x[15:0];
  endfunction

  // swab is always a word operation
  assign byte_eff = item.byte_mode &&
                    !(item.kind == wbalu_pkg::KIND_ONE_OP && item.op == wbalu_pkg::OP1_SWAB);
  assign a      = byte_eff ? {9'd0, item.src_value[7:0]} : {1'b0, item.src_value};
  assign d      = byte_eff ? {9'd0, item.dst_value[7:0]} : {1'b0, item.dst_value};
  assign sign17 = byte_eff ? 17'h00080 : 17'h08000;
  assign cin    = flags_in.c;

  // operation decode and flag update
  always_comb begin
    r      = '0;
    wr     = 1'b0;
    wsrc   = 1'b0;
    srcres = '0;
    res16  = '0;
    taken  = 1'b0;
    upd_nz = 1'b0;
    shift  = 1'b0;
    nc     = 1'b0;
    fl     = flags_in;

    unique case (item.kind)
      wbalu_pkg::KIND_TWO_OP: begin
        wr     = 1'b1;
        upd_nz = 1'b1;
        fl.v   = 1'b0;
        case (item.op)
          wbalu_pkg::OP2_XCHG: begin
            r      = a;
            srcres = widen(d, byte_eff);
            wsrc   = 1'b1;
          end
          wbalu_pkg::OP2_MOV: r = a;
          wbalu_pkg::OP2_CMP: begin
            r    = a - d;
            wr   = 1'b0;
            fl.v = sign_of((a ^ d) & ~(d ^ r), byte_eff);
            fl.c = carry_of(r, byte_eff);
          end
          wbalu_pkg::OP2_BIT: begin
            r  = d & a;
            wr = 1'b0;
          end
          wbalu_pkg::OP2_BIC: r = d & ~a;
          wbalu_pkg::OP2_BIS: r = d | a;
          wbalu_pkg::OP2_AND: r = d & a;
          wbalu_pkg::OP2_XOR: r = d ^ a;
          wbalu_pkg::OP2_ADD: begin
            r    = d + a;
            fl.v = sign_of(~(a ^ d) & (d ^ r), byte_eff);
            fl.c = carry_of(r, byte_eff);
          end
          wbalu_pkg::OP2_SUB: begin
            r    = d - a;
            fl.v = sign_of((a ^ d) & ~(a ^ r), byte_eff);
            fl.c = carry_of(r, byte_eff);
          end
          default: begin
            // unknown operation leaves everything alone
            wr     = 1'b0;
            upd_nz = 1'b0;
            fl     = flags_in;
          end
        endcase
        if (wr) begin
          res16 = widen(r, byte_eff);
        end
      end

      wbalu_pkg::KIND_ONE_OP: begin
        wr     = 1'b1;
        upd_nz = 1'b1;
        case (item.op)
          wbalu_pkg::OP1_SWAB: begin
            r      = {1'b0, d[7:0], d[15:8]};
            upd_nz = 1'b0;
            fl.n   = r[7];
            fl.z   = (r[7:0] == 8'h00);
            fl.v   = 1'b0;
            fl.c   = 1'b0;
          end
          wbalu_pkg::OP1_CLR: begin
            r    = '0;
            fl.v = 1'b0;
            fl.c = 1'b0;
          end
          wbalu_pkg::OP1_COM: begin
            r    = ~d;
            fl.v = 1'b0;
            fl.c = 1'b1;
          end
          wbalu_pkg::OP1_INC: begin
            r    = d + 17'd1;
            fl.v = sign_of(~d & r, byte_eff);
          end
          wbalu_pkg::OP1_DEC: begin
            r    = d - 17'd1;
            fl.v = sign_of(d & ~r, byte_eff);
          end
          wbalu_pkg::OP1_NEG: begin
            r    = (17'd0 - d) & (byte_eff ? 17'h000FF : 17'h0FFFF);
            fl.v = (r == sign17);
            fl.c = (r != 17'd0);
          end
          wbalu_pkg::OP1_ADC: begin
            r    = d + {16'd0, cin};
            fl.v = sign_of(~d & r, byte_eff);
            fl.c = carry_of(r, byte_eff);
          end
          wbalu_pkg::OP1_SBC: begin
            r    = d - {16'd0, cin};
            fl.v = sign_of(d & ~r, byte_eff);
            fl.c = carry_of(r, byte_eff);
          end
          wbalu_pkg::OP1_TST: begin
            r    = d;
            fl.v = 1'b0;
            fl.c = 1'b0;
          end
          wbalu_pkg::OP1_ROR: begin
            shift = 1'b1;
            nc    = d[0];
            r     = (d >> 1) | (cin ? sign17 : 17'd0);
          end
          wbalu_pkg::OP1_ROL: begin
            shift = 1'b1;
            nc    = sign_of(d, byte_eff);
            r     = (d << 1) | {16'd0, cin};
          end
          wbalu_pkg::OP1_ASR: begin
            shift = 1'b1;
            nc    = d[0];
            r     = (d >> 1) | (d & sign17);
          end
          wbalu_pkg::OP1_ASL: begin
            shift = 1'b1;
            nc    = sign_of(d, byte_eff);
            r     = d << 1;
          end
          wbalu_pkg::OP1_RCR: begin
            shift = 1'b1;
            nc    = d[0];
            r     = (d >> 1) | (d[0] ? sign17 : 17'd0);
          end
          wbalu_pkg::OP1_RCL: begin
            shift = 1'b1;
            nc    = sign_of(d, byte_eff);
            r     = (d << 1) | {16'd0, nc};
          end
          default: begin
            wr     = 1'b0;
            upd_nz = 1'b0;
          end
        endcase
        // shifts and rotates: v is n xor the bit shifted out
        if (shift) begin
          fl.v = sign_of(r, byte_eff) ^ nc;
          fl.c = nc;
        end
        if (wr) begin
          res16 = widen(r, byte_eff);
        end
      end

      wbalu_pkg::KIND_FLAGS: begin
        if (item.byte_mode) begin
          fl = wbalu_pkg::flags_t'(flags_in | item.flag_mask);
        end else begin
          fl = wbalu_pkg::flags_t'(flags_in & ~item.flag_mask);
        end
      end

      wbalu_pkg::KIND_BRANCH: begin
        unique case (item.op)
          wbalu_pkg::BR_BR:   taken = 1'b1;
          wbalu_pkg::BR_BNE:  taken = !flags_in.z;
          wbalu_pkg::BR_BEQ:  taken = flags_in.z;
          wbalu_pkg::BR_BGE:  taken = (flags_in.n == flags_in.v);
          wbalu_pkg::BR_BLT:  taken = (flags_in.n != flags_in.v);
          wbalu_pkg::BR_BGT:  taken = !(flags_in.z || (flags_in.n != flags_in.v));
          wbalu_pkg::BR_BLE:  taken = flags_in.z || (flags_in.n != flags_in.v);
          wbalu_pkg::BR_BPL:  taken = !flags_in.n;
          wbalu_pkg::BR_BMI:  taken = flags_in.n;
          wbalu_pkg::BR_BHI:  taken = !(flags_in.z || flags_in.c);
          wbalu_pkg::BR_BLOS: taken = flags_in.z || flags_in.c;
          wbalu_pkg::BR_BVC:  taken = !flags_in.v;
          wbalu_pkg::BR_BVS:  taken = flags_in.v;
          wbalu_pkg::BR_BCC:  taken = !flags_in.c;
          wbalu_pkg::BR_BCS:  taken = flags_in.c;
          default:            taken = 1'b0;
        endcase
      end

      wbalu_pkg::KIND_COUNT: begin
        // count-down is always word wide, flags untouched
        res16 = item.dst_value - 16'd1;
        wr    = 1'b1;
        taken = (res16 != 16'd0);
      end

      default: begin
      end
    endcase

    if (upd_nz) begin
      fl.n = sign_of(r, byte_eff);
      fl.z = zero_of(r, byte_eff);
    end
  end

  assign res.result       = res16;
  assign res.write_result = wr;
  assign res.src_result   = srcres;
  assign res.write_src    = wsrc;
  assign res.flags        = fl;
  assign res.branch_taken = taken;

endmodule

// ===== hdl/wbalu_out_stage.sv =====
// output register: holds one result word until the receiver takes it
module wbalu_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  wbalu_pkg::res_t  load_data,
  input  logic             out_stall,
  output logic             ready,
  output logic             out_valid,
  output wbalu_pkg::res_t  out_data
);

  // free when empty or the held word leaves this cycle
  assign ready = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hdl/word_byte_alu_with_condition_codes_top.sv =====
// top level: input register, flag register, alu and output register
//
// Word/byte ALU with N, Z, V, C condition codes.
// Input channel: in_valid / in_stall with kind, op, byte_mode, src_value,
// dst_value and flag_mask; a word is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with result,
// write_result, src_result, write_src, the four flags and branch_taken;
// one result word leaves for every input word, in order.
// A taken word sits in the input register, passes the alu and lands in the
// output register, where out_valid rises. Throughput is one word per cycle
// while the receiver does not stall; the loop through the flag register
// closes through the combinational alu, so every word sees the flags left by
// the word before it.
// Reset clears both valid flags and all condition codes.
// While the receiver stalls, the output register holds its word and the
// input register can still take one more; in_stall rises only when both
// are full.
module word_byte_alu_with_condition_codes_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [5:0]  op,
  input  logic        byte_mode,
  input  logic [15:0] src_value,
  input  logic [15:0] dst_value,
  input  logic [3:0]  flag_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result,
  output logic        write_result,
  output logic [15:0] src_result,
  output logic        write_src,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_v,
  output logic        flag_c,
  output logic        branch_taken
);

  logic               s1_valid;
  logic               s1_valid_next;
  wbalu_pkg::item_t   s1_item;
  wbalu_pkg::flags_t  flags;
  wbalu_pkg::res_t    exec_res;
  wbalu_pkg::res_t    out_data;
  logic               out_ready;
  logic               accept;
  logic               advance;

  // handshake
  assign advance  = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= '{kind: kind, op: op, byte_mode: byte_mode, src_value: src_value,
                   dst_value: dst_value, flag_mask: flag_mask};
    end
  end

  // condition codes follow each word as it leaves the alu
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= exec_res.flags;
    end
  end

  wbalu_exec u_exec (
    .item     (s1_item),
    .flags_in (flags),
    .res      (exec_res)
  );

  wbalu_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_data  (exec_res),
    .out_stall  (out_stall),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // result ports
  assign result       = out_data.result;
  assign write_result = out_data.write_result;
  assign src_result   = out_data.src_result;
  assign write_src    = out_data.write_src;
  assign flag_n       = out_data.flags.n;
  assign flag_z       = out_data.flags.z;
  assign flag_v       = out_data.flags.v;
  assign flag_c       = out_data.flags.c;
  assign branch_taken = out_data.branch_taken;

`ifndef NO_ASSERTIONS
  // flags move only when a word passes the alu
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(flags))
    else $error("condition codes changed with no word in the alu");

  // input side stalls only when the input register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // exchange always writes the destination too
  a_xchg_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_src |-> write_result)
    else $error("source write without destination write");

  // a written result with branch taken is a count-down with nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken && write_result |-> result != 16'd0)
    else $error("count-down branch taken on zero count");
`endif

endmodule
